// ===== rtl/core/casu_pkg.sv =====
// Package for the channel argmax segmentation unit.
// Holds sizes, register indexes and the shared float compare function.
`default_nettype none
package casu_pkg;
  localparam int unsigned MAX_PIXELS_DEF   = 16384;
  localparam int unsigned MAX_CHANNELS_DEF = 256;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned CLASS_W = 8;
  localparam int unsigned CFG_W   = 15;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 1'b0,
    REG_PLANE_PIXELS  = 1'b1
  } cfg_reg_t;

  // IEEE strict greater-than on raw bits; NaN never wins, +0 equals -0.
  function automatic logic fp_greater(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    logic nan_a;
    logic nan_b;
    nan_a = (a[30:0] > 31'h7F800000);
    nan_b = (b[30:0] > 31'h7F800000);
    ka = a[31] ? ~a : {1'b1, a[30:0]};
    kb = b[31] ? ~b : {1'b1, b[30:0]};
    if (nan_a || nan_b) begin
      return 1'b0;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      return 1'b0;
    end else begin
      return ka > kb;
    end
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/channel_argmax_segmentation_unit.sv =====
// Top level of the per-pixel channel argmax segmentation unit.
// Depends on casu_pkg, casu_front, casu_back, casu_queue, casu_ram.
//
//  Channel | Ports                                   | Direction
//  input   | in_valid, in_stall, in_score_bits       | score beats in
//  result  | out_valid, out_stall, out_class_index,  | class beats out
//          | out_frame_end                           |
//  config  | cfg_we, cfg_index, cfg_wdata            | register writes in
//
// One score beat is taken per cycle while in_stall is low. The store read
// is issued at the edge that accepts a score; in the next cycle the score is
// compared and written back, and at that same edge the class beat is
// registered, then written into the output queue, raising out_valid.
// Back-to-back hits on the same pixel are resolved by a write forward
// register. in_stall rises only when the four-entry result queue could not
// absorb all beats in flight. Reset is synchronous and active low; the
// stores need no clearing since channel zero always writes first.
`default_nettype none
module channel_argmax_segmentation_unit #(
  parameter int unsigned MAX_PIXELS   = casu_pkg::MAX_PIXELS_DEF,
  parameter int unsigned MAX_CHANNELS = casu_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [casu_pkg::CFG_IDX_W:0] cfg_index,
  input  wire logic [casu_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic [31:0]                  in_score_bits,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [7:0]                   out_class_index,
  output      logic                         out_frame_end
);
  import casu_pkg::*;
  localparam int unsigned PX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned QD   = 4;

  logic            take;
  logic [PX_W-1:0] px;
  logic [CH_W-1:0] ch;
  logic            first_ch, last_ch, last_px;
  logic            res_valid;
  logic [CLASS_W-1:0] res_class;
  logic            res_end;
  logic [$clog2(QD):0] q_cnt;
  logic [1:0]      inflight_r;

  // Beats in the two back stages may still land in the queue; keep room.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= {inflight_r[0], take};
    end
  end
  assign in_stall = (32'(q_cnt) + 32'(inflight_r[0]) + 32'(inflight_r[1])) >= QD;
  assign take = in_valid && !in_stall;

  casu_front #(.MAX_PIXELS(MAX_PIXELS), .MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .take(take), .px(px), .ch(ch),
    .first_ch(first_ch), .last_ch(last_ch), .last_px(last_px));

  casu_back #(.MAX_PIXELS(MAX_PIXELS), .CH_W(CH_W)) u_back (
    .clk(clk), .rst_n(rst_n), .go(take), .px(px), .ch(ch),
    .first_ch(first_ch), .last_ch(last_ch), .last_px(last_px),
    .score(in_score_bits), .res_valid(res_valid), .res_class(res_class),
    .res_end(res_end));

  casu_queue #(.DEPTH(QD)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(res_valid), .push_class(res_class),
    .push_end(res_end), .count(q_cnt), .out_valid(out_valid),
    .out_stall(out_stall), .out_class(out_class_index), .out_end(out_frame_end));

  ap_room: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (q_cnt < 3'(QD)))
    else $error("accepted a beat without queue room");
  ap_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt == 3'(QD)) |-> in_stall)
    else $error("input open with full queue");
  ap_track: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> inflight_r[0])
    else $error("in-flight tracking lost a beat");
endmodule
`default_nettype wire

// ===== rtl/core/casu_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module casu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/casu_front.sv =====
// Front part: tracks pixel and channel positions of accepted scores, applies config writes.
// Depends on casu_pkg.
`default_nettype none
module casu_front #(
  parameter int unsigned MAX_PIXELS   = casu_pkg::MAX_PIXELS_DEF,
  parameter int unsigned MAX_CHANNELS = casu_pkg::MAX_CHANNELS_DEF,
  localparam int unsigned PX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
  localparam int unsigned CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [casu_pkg::CFG_IDX_W:0]  cfg_index,
  input  wire logic [casu_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic                          take,
  output      logic [PX_W-1:0]               px,
  output      logic [CH_W-1:0]               ch,
  output      logic                          first_ch,
  output      logic                          last_ch,
  output      logic                          last_px
);
  import casu_pkg::*;
  logic [8:0]      chan_cnt_r;
  logic [14:0]     pix_cnt_r;
  logic [PX_W-1:0] px_r, px_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  logic [CH_W:0]   eff_ch;
  logic [PX_W:0]   eff_px;
  logic            cfg_hit;

  always_comb begin
    if (chan_cnt_r == 9'd0) begin
      eff_ch = (CH_W+1)'(1);
    end else if (32'(chan_cnt_r) > MAX_CHANNELS) begin
      eff_ch = (CH_W+1)'(MAX_CHANNELS);
    end else begin
      eff_ch = (CH_W+1)'(chan_cnt_r);
    end
    if (pix_cnt_r == 15'd0) begin
      eff_px = (PX_W+1)'(1);
    end else if (32'(pix_cnt_r) > MAX_PIXELS) begin
      eff_px = (PX_W+1)'(MAX_PIXELS);
    end else begin
      eff_px = (PX_W+1)'(pix_cnt_r);
    end
  end

  assign px       = px_r;
  assign ch       = ch_r;
  assign first_ch = (ch_r == '0);
  assign last_ch  = ({1'b0, ch_r} == eff_ch - 1'b1);
  assign last_px  = ({1'b0, px_r} == eff_px - 1'b1);
  assign cfg_hit  = cfg_we && (cfg_index <= (CFG_IDX_W+1)'(REG_PLANE_PIXELS));

  always_comb begin
    px_nxt = px_r;
    ch_nxt = ch_r;
    if (take) begin
      if (last_px) begin
        px_nxt = '0;
        ch_nxt = last_ch ? '0 : ch_r + 1'b1;
      end else begin
        px_nxt = px_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= 9'd1;
      pix_cnt_r  <= 15'd1;
      px_r       <= '0;
      ch_r       <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == (CFG_IDX_W+1)'(REG_CHANNEL_COUNT)) begin
        chan_cnt_r <= cfg_wdata[8:0];
      end else begin
        pix_cnt_r <= cfg_wdata;
      end
      px_r <= '0;
      ch_r <= '0;
    end else begin
      px_r <= px_nxt;
      ch_r <= ch_nxt;
    end
  end

  ap_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (take && last_px && last_ch && !cfg_we) |=> (px_r == '0 && ch_r == '0))
    else $error("position did not wrap at frame end");
  ap_step: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !last_px && !cfg_we) |=> (px_r == $past(px_r) + 1'b1))
    else $error("pixel position did not advance");
  ap_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (px_r == '0))
    else $error("config write did not restart frame");
endmodule
`default_nettype wire

// ===== rtl/core/casu_back.sv =====
// Back part: compares each score with the stored best (channel zero overwrites it) and updates the stores.
// Depends on casu_pkg and casu_ram.
`default_nettype none
module casu_back #(
  parameter int unsigned MAX_PIXELS = casu_pkg::MAX_PIXELS_DEF,
  parameter int unsigned CH_W = 8,
  localparam int unsigned PX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         go,
  input  wire logic [PX_W-1:0]              px,
  input  wire logic [CH_W-1:0]              ch,
  input  wire logic                         first_ch,
  input  wire logic                         last_ch,
  input  wire logic                         last_px,
  input  wire logic [casu_pkg::SCORE_W-1:0] score,
  output      logic                         res_valid,
  output      logic [casu_pkg::CLASS_W-1:0] res_class,
  output      logic                         res_end
);
  import casu_pkg::*;
  // Stage 1 holds the item while the store read completes.
  logic              s1_v_r;
  logic [PX_W-1:0]   s1_px_r;
  logic [CH_W-1:0]   s1_ch_r;
  logic              s1_first_r, s1_last_r, s1_end_r;
  logic [SCORE_W-1:0] s1_score_r;
  logic [SCORE_W-1:0] rd_score;
  logic [CLASS_W-1:0] rd_class;
  // Forward register for a read of the entry being written the same cycle.
  logic              fw_v_r;
  logic [PX_W-1:0]   fw_px_r;
  logic [SCORE_W-1:0] fw_score_r;
  logic [CLASS_W-1:0] fw_class_r;
  logic [SCORE_W-1:0] cur_score;
  logic [CLASS_W-1:0] cur_class;
  logic              wr;
  logic [SCORE_W-1:0] w_score;
  logic [CLASS_W-1:0] w_class;

  casu_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_PIXELS)) u_score (
    .clk(clk), .we(wr), .waddr(s1_px_r), .wdata(w_score),
    .re(go), .raddr(px), .rdata(rd_score));
  casu_ram #(.WIDTH(CLASS_W), .DEPTH(MAX_PIXELS)) u_class (
    .clk(clk), .we(wr), .waddr(s1_px_r), .wdata(w_class),
    .re(go), .raddr(px), .rdata(rd_class));

  always_comb begin
    cur_score = (fw_v_r && fw_px_r == s1_px_r) ? fw_score_r : rd_score;
    cur_class = (fw_v_r && fw_px_r == s1_px_r) ? fw_class_r : rd_class;
    w_score = cur_score;
    w_class = cur_class;
    if (s1_first_r) begin
      w_score = s1_score_r;
      w_class = '0;
    end else if (fp_greater(s1_score_r, cur_score)) begin
      w_score = s1_score_r;
      w_class = CLASS_W'(s1_ch_r);
    end
  end
  assign wr = s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      fw_v_r    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s1_v_r    <= go;
      fw_v_r    <= wr && go && (px == s1_px_r);
      res_valid <= s1_v_r && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_px_r    <= px;
      s1_ch_r    <= ch;
      s1_first_r <= first_ch;
      s1_last_r  <= last_ch;
      s1_end_r   <= last_px;
      s1_score_r <= score;
    end
    fw_px_r    <= s1_px_r;
    fw_score_r <= w_score;
    fw_class_r <= w_class;
    if (s1_v_r && s1_last_r) begin
      res_class <= w_class;
      res_end   <= s1_end_r;
    end
  end

  ap_first: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_first_r) |-> (w_class == '0 && w_score == s1_score_r))
    else $error("first channel did not overwrite the entry");
  ap_res: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> $past(s1_v_r && s1_last_r))
    else $error("result without last-channel item");
  ap_fw: assert property (@(posedge clk) disable iff (!rst_n)
    fw_v_r |-> $past(s1_v_r && go))
    else $error("forward without back-to-back item");
endmodule
`default_nettype wire

// ===== rtl/core/casu_queue.sv =====
// Short result queue between the compare pipeline and the output channel.
// Depends on casu_pkg.
`default_nettype none
module casu_queue #(
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire logic [casu_pkg::CLASS_W-1:0] push_class,
  input  wire logic                         push_end,
  output      logic [AW:0]                  count,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [casu_pkg::CLASS_W-1:0] out_class,
  output      logic                         out_end
);
  import casu_pkg::*;
  logic [CLASS_W:0] q_r [DEPTH];
  logic [AW-1:0] rd_r, wr_r;
  logic [AW:0]   cnt_r;
  logic          pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign out_class = q_r[rd_r][CLASS_W-1:0];
  assign out_end   = q_r[rd_r][CLASS_W];
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= {push_end, push_class};
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  ap_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < (AW+1)'(DEPTH) || pop))
    else $error("result queue overflow");
endmodule
`default_nettype wire
